// File: rtl/core/bpoa_pkg.sv
// Package with the transaction types and codes of the buffer pool allocator.
`default_nettype none

package bpoa_pkg;

  // Request codes.
  localparam logic [1:0] REQ_CHECKOUT = 2'd0;
  localparam logic [1:0] REQ_CHECKIN  = 2'd1;
  localparam logic [1:0] REQ_RELEASE  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_ALL_BUSY     = 3'd1;
  localparam logic [2:0] ST_INVALID      = 3'd2;
  localparam logic [2:0] ST_NOT_OUT      = 3'd3;
  localparam logic [2:0] ST_WRONG_OWNER  = 3'd4;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] requester;
    logic [3:0] buffer_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  granted_slot;
    logic [4:0]  active_count;
    logic [31:0] grant_tally;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bpoa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module bpoa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/buffer_pool_owner_allocator_unit.sv
// Top level of the buffer pool allocator: checkout, checkin and force release of slots.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   in      | input     | in_valid / stall   | bpoa_pkg::req_t
//   out     | output    | out_valid / stall  | bpoa_pkg::rsp_t
//   cfg     | input     | cfg_valid / ready  | slots_in_use, 5 bits
//
// For each transaction, the accept edge reads the owner and hint RAMs,
// and the next edge evaluates the request, writes back and loads the result register.
// No new request is taken while the previous one is being evaluated.
// Reset clears the busy map, the hint valid bits, the counters and sets 16 slots in use.
// While the result register is full and stalled, no new request is accepted.
`default_nettype none

module buffer_pool_owner_allocator_unit #(
  parameter int NUM_SLOTS      = 16,
  parameter int NUM_REQUESTERS = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire bpoa_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bpoa_pkg::rsp_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [4:0]     cfg_data_i
);

  import bpoa_pkg::*;

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int ReqW  = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
  localparam int CntW  = $clog2(NUM_SLOTS + 1);

  logic [4:0]          cfg_q;
  logic                exec_q;
  req_t                req_q;
  logic [ReqW-1:0]     who_q;
  logic                hint_hit_q;
  logic [NUM_SLOTS-1:0]      busy_q, busy_d;
  logic [NUM_REQUESTERS-1:0] hint_set_q, hint_set_d;
  logic [CntW-1:0]     active_q, active_d;
  logic [31:0]         tally_q, tally_d;
  logic                out_valid_q;
  rsp_t                out_q;

  logic                in_acc;
  logic [6:0]          who_ext;
  logic [ReqW-1:0]     who_in;
  logic [ReqW-1:0]     owner_rd;
  logic [SlotW-1:0]    hint_rd;
  logic [SlotW-1:0]    hint;
  logic [8:0]          pool_n;
  logic                slot_busy, hint_busy, free_found;
  logic [SlotW-1:0]    free_idx, grant_idx;
  logic                grant, hint_wr, clear_slot;
  logic [2:0]          status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = exec_q | (out_valid_q & out_stall_i);
  assign in_acc      = in_valid_i & ~in_stall_o;

  // Requester identity folded into the configured number of requesters.
  always_comb begin
    who_ext = {4'b0, in_data_i.requester};
    for (int k = 0; k < 8; k++) begin
      if (who_ext >= 7'(NUM_REQUESTERS)) begin
        who_ext = who_ext - 7'(NUM_REQUESTERS);
      end
    end
    who_in = who_ext[ReqW-1:0];
  end

  bpoa_ram #(.Width(ReqW), .Depth(NUM_SLOTS)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (grant),
    .waddr_i (grant_idx),
    .wdata_i (who_q),
    .re_i    (in_acc),
    .raddr_i (SlotW'(in_data_i.buffer_slot)),
    .rdata_o (owner_rd)
  );

  bpoa_ram #(.Width(SlotW), .Depth(NUM_REQUESTERS)) u_hint_ram (
    .clk_i   (clk_i),
    .we_i    (hint_wr),
    .waddr_i (who_q),
    .wdata_i (free_idx),
    .re_i    (in_acc),
    .raddr_i (who_in),
    .rdata_o (hint_rd)
  );

  // Hints never written read as slot zero.
  assign hint   = hint_hit_q ? hint_rd : '0;
  assign pool_n = (9'(cfg_q) > 9'(NUM_SLOTS)) ? 9'(NUM_SLOTS) : 9'(cfg_q);

  always_comb begin
    slot_busy  = 1'b0;
    hint_busy  = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (9'(i) == 9'(req_q.buffer_slot)) begin
        slot_busy = busy_q[i];
      end
      if (SlotW'(i) == hint) begin
        hint_busy = busy_q[i];
      end
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i] && (9'(i) < pool_n)) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  always_comb begin
    status     = ST_OK;
    grant      = 1'b0;
    hint_wr    = 1'b0;
    clear_slot = 1'b0;
    grant_idx  = free_idx;
    if (exec_q) begin
      unique case (req_q.req_type)
        REQ_CHECKOUT: begin
          if ((9'(hint) < pool_n) && !hint_busy) begin
            grant     = 1'b1;
            grant_idx = hint;
          end else if (free_found) begin
            grant   = 1'b1;
            hint_wr = 1'b1;
          end else begin
            status = ST_ALL_BUSY;
          end
        end
        REQ_CHECKIN: begin
          if (9'(req_q.buffer_slot) >= pool_n) begin
            status = ST_INVALID;
          end else if (!slot_busy) begin
            status = ST_NOT_OUT;
          end else if (owner_rd != who_q) begin
            status = ST_WRONG_OWNER;
          end else begin
            clear_slot = 1'b1;
          end
        end
        REQ_RELEASE: begin
          if (9'(req_q.buffer_slot) >= pool_n) begin
            status = ST_INVALID;
          end else if (!slot_busy) begin
            status = ST_ALREADY_FREE;
          end else begin
            clear_slot = 1'b1;
          end
        end
        default: begin
          status = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    busy_d     = busy_q;
    hint_set_d = hint_set_q;
    active_d   = active_q;
    tally_d    = tally_q;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (grant && (SlotW'(i) == grant_idx)) begin
        busy_d[i] = 1'b1;
      end
      if (clear_slot && (9'(i) == 9'(req_q.buffer_slot))) begin
        busy_d[i] = 1'b0;
      end
    end
    if (hint_wr) begin
      hint_set_d[who_q] = 1'b1;
    end
    if (grant) begin
      active_d = active_q + CntW'(1);
      tally_d  = tally_q + 32'd1;
    end else if (clear_slot) begin
      active_d = active_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= 5'd16;
      exec_q      <= 1'b0;
      busy_q      <= '0;
      hint_set_q  <= '0;
      active_q    <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      exec_q     <= in_acc;
      busy_q     <= busy_d;
      hint_set_q <= hint_set_d;
      active_q   <= active_d;
      tally_q    <= tally_d;
      if (exec_q) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q      <= in_data_i;
      who_q      <= who_in;
      hint_hit_q <= hint_set_q[who_in];
    end
    if (exec_q) begin
      out_q.status       <= status;
      out_q.granted_slot <= grant ? 4'(grant_idx) : 4'd0;
      out_q.active_count <= 5'(active_d);
      out_q.grant_tally  <= tally_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // The active count always matches the number of busy slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(active_q) == 32'($countones(busy_q)))
    else $error("active count out of step with busy map");

  // An accepted transaction is evaluated in the following cycle and produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (exec_q ##1 out_valid_q))
    else $error("accepted transaction produced no result");

  // The checkout tally only moves when a transaction is evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q != $past(tally_q)) |-> $past(exec_q))
    else $error("checkout tally changed without a transaction");

  // A result can only be granted by a checkout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grant |-> (exec_q && (req_q.req_type == REQ_CHECKOUT) && (status == ST_OK)))
    else $error("grant outside a successful checkout");
`endif

endmodule

`default_nettype wire

// File: sim/tb_buffer_pool_owner_allocator_unit.sv
// Self-checking testbench of the buffer pool allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_buffer_pool_owner_allocator_unit;
  import bpoa_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int NUM_REQUESTERS = 8;
  localparam int QUIET_LIMIT    = 3000;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int LONG_HOLD      = 400;
  // Request type with no defined meaning.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  req_t in_data;
  logic out_valid_o;
  logic out_stall;
  rsp_t out_data_o;
  logic cfg_valid;
  logic cfg_ready_o;
  logic [4:0] cfg_data;

  buffer_pool_owner_allocator_unit #(
    .NUM_SLOTS      (NUM_SLOTS),
    .NUM_REQUESTERS (NUM_REQUESTERS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  // Shadow state of the pool.
  logic [4:0]  pool_cfg;
  logic        busy_map [NUM_SLOTS];
  logic [2:0]  owner_tbl [NUM_SLOTS];
  logic [3:0]  hint_tbl [NUM_REQUESTERS];
  logic [4:0]  active_cnt;
  logic [31:0] checkout_cnt;

  rsp_t due_replies [$];
  int   bad_replies;
  int   replies_seen;
  int   gap_cap;
  int   stall_cap;
  bit   hold_done;

  typedef struct {
    bit         is_cfg;
    logic [4:0] pool;
    req_t       req;
    bit         typed;
    rsp_t       rsp;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pool_limit();
    return (pool_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(pool_cfg);
  endfunction

  function automatic void take_slot(int slot, logic [2:0] who);
    busy_map[slot]  = 1'b1;
    owner_tbl[slot] = who;
    active_cnt++;
    checkout_cnt++;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t       res;
    int         n;
    logic [2:0] who;
    logic [3:0] h;
    bit         found;
    n = pool_limit();
    who = r.requester;
    res.status = ST_OK;
    res.granted_slot = '0;
    found = 1'b0;
    case (r.req_type)
      REQ_CHECKOUT: begin
        h = hint_tbl[who];
        if (int'(h) < n && !busy_map[h]) begin
          take_slot(int'(h), who);
          res.granted_slot = h;
        end else begin
          for (int i = 0; i < n && !found; i++) begin
            if (!busy_map[i]) begin
              take_slot(i, who);
              hint_tbl[who] = i[3:0];
              res.granted_slot = i[3:0];
              found = 1'b1;
            end
          end
          if (!found) res.status = ST_ALL_BUSY;
        end
      end
      REQ_CHECKIN: begin
        if (int'(r.buffer_slot) >= n) res.status = ST_INVALID;
        else if (!busy_map[r.buffer_slot]) res.status = ST_NOT_OUT;
        else if (owner_tbl[r.buffer_slot] != who) res.status = ST_WRONG_OWNER;
        else begin
          busy_map[r.buffer_slot] = 1'b0;
          active_cnt--;
        end
      end
      REQ_RELEASE: begin
        if (int'(r.buffer_slot) >= n) res.status = ST_INVALID;
        else if (!busy_map[r.buffer_slot]) res.status = ST_ALREADY_FREE;
        else begin
          busy_map[r.buffer_slot] = 1'b0;
          active_cnt--;
        end
      end
      default: res.status = ST_INVALID;
    endcase
    res.active_count = active_cnt;
    res.grant_tally = checkout_cnt;
    return res;
  endfunction

  // Mostly checkouts and owner-correct returns of held slots, some forced releases of held slots, the rest raw noise.
  function automatic req_t draw_request();
    req_t       r;
    int         n;
    int         pick;
    logic [3:0] held [$];
    n = pool_limit();
    pick = $urandom_range(0, 99);
    r.req_type = 2'($urandom_range(0, 3));
    r.requester = 3'($urandom_range(0, 7));
    r.buffer_slot = 4'($urandom_range(0, 15));
    if (pick < 40) begin
      r.req_type = REQ_CHECKOUT;
    end else if (pick < 80) begin
      for (int i = 0; i < n; i++) begin
        if (busy_map[i]) held.push_back(i[3:0]);
      end
      if (held.size() == 0) begin
        r.req_type = REQ_CHECKOUT;
      end else begin
        r.buffer_slot = held[$urandom_range(0, held.size() - 1)];
        if (pick < 70) begin
          r.req_type = REQ_CHECKIN;
          r.requester = owner_tbl[r.buffer_slot];
        end else begin
          r.req_type = REQ_RELEASE;
        end
      end
    end
    return r;
  endfunction

  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    int   gap;
    rsp_t res;
    gap = $urandom_range(0, gap_cap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_request(r);
    due_replies.push_back(typed ? typed_rsp : res);
  endtask

  // Waits until the pool has answered everything, then writes the pool size.
  task automatic write_pool(logic [4:0] v);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool_cfg = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic cfg_row(logic [4:0] v);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.pool = v;
    dir_rows.push_back(row);
  endtask

  task automatic req_row(logic [1:0] t, logic [2:0] who, logic [3:0] slot, bit typed,
                         logic [2:0] st, logic [3:0] gs, logic [4:0] ac, logic [31:0] tc);
    dir_row_t row;
    row = '{default: '0};
    row.req.req_type = t;
    row.req.requester = who;
    row.req.buffer_slot = slot;
    row.typed = typed;
    row.rsp.status = st;
    row.rsp.granted_slot = gs;
    row.rsp.active_count = ac;
    row.rsp.grant_tally = tc;
    dir_rows.push_back(row);
  endtask

  // Checks every reply against the oldest one still due.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      replies_seen++;
      if (due_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= 10) $display("unexpected reply %p", out_data_o);
      end else begin
        want = due_replies.pop_front();
        if (out_data_o.status !== want.status ||
            out_data_o.granted_slot !== want.granted_slot ||
            out_data_o.active_count !== want.active_count ||
            out_data_o.grant_tally !== want.grant_tally) begin
          bad_replies++;
          if (bad_replies <= 10) begin
            $display("reply differs: expected %p, got %p", want, out_data_o);
          end
        end
      end
    end
  end

  // Receiver: random stall per transaction, one long hold-off once traffic is going.
  initial begin
    int w;
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      w = $urandom_range(0, stall_cap);
      if (!hold_done && replies_seen >= 100) begin
        w = LONG_HOLD;
        hold_done = 1'b1;
      end
      repeat (w) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("buffer_pool_owner_allocator_unit: mismatch");
    $finish;
  end

  initial begin
    logic [4:0] phase_pool [10];
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    bad_replies = 0;
    replies_seen = 0;
    gap_cap = 18;
    stall_cap = 18;
    pool_cfg = 5'd16;
    active_cnt = '0;
    checkout_cnt = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      busy_map[i] = 1'b0;
      owner_tbl[i] = '0;
    end
    for (int i = 0; i < NUM_REQUESTERS; i++) hint_tbl[i] = '0;
    phase_pool = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd16, 5'd2, 5'd31, 5'd8, 5'd3, 5'd16};

    // Full pool after reset: hints, owner checks, double frees, the unknown request type.
    req_row(REQ_CHECKOUT, 3'd0, 4'd0,  1, ST_OK,           4'd0, 5'd1, 32'd1);
    req_row(REQ_CHECKOUT, 3'd0, 4'd15, 1, ST_OK,           4'd1, 5'd2, 32'd2);
    req_row(REQ_CHECKIN,  3'd1, 4'd0,  1, ST_WRONG_OWNER,  4'd0, 5'd2, 32'd2);
    req_row(REQ_CHECKIN,  3'd0, 4'd0,  1, ST_OK,           4'd0, 5'd1, 32'd2);
    req_row(REQ_CHECKIN,  3'd0, 4'd0,  1, ST_NOT_OUT,      4'd0, 5'd1, 32'd2);
    req_row(REQ_RELEASE,  3'd5, 4'd1,  1, ST_OK,           4'd0, 5'd0, 32'd2);
    req_row(REQ_RELEASE,  3'd5, 4'd1,  1, ST_ALREADY_FREE, 4'd0, 5'd0, 32'd2);
    req_row(REQ_RELEASE,  3'd7, 4'd15, 1, ST_ALREADY_FREE, 4'd0, 5'd0, 32'd2);
    req_row(REQ_UNKNOWN,  3'd7, 4'd15, 1, ST_INVALID,      4'd0, 5'd0, 32'd2);
    req_row(REQ_CHECKOUT, 3'd7, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_CHECKOUT, 3'd0, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_CHECKOUT, 3'd0, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    // Pool shrinks onto three busy slots.
    cfg_row(5'd3);
    req_row(REQ_CHECKOUT, 3'd3, 4'd0,  1, ST_ALL_BUSY,     4'd0, 5'd3, 32'd5);
    req_row(REQ_CHECKIN,  3'd0, 4'd3,  1, ST_INVALID,      4'd0, 5'd3, 32'd5);
    req_row(REQ_RELEASE,  3'd7, 4'd15, 1, ST_INVALID,      4'd0, 5'd3, 32'd5);
    req_row(REQ_CHECKIN,  3'd0, 4'd2,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    // A single slot: the hint of requester 0 now lies outside the pool.
    cfg_row(5'd1);
    req_row(REQ_CHECKOUT, 3'd0, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_RELEASE,  3'd4, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_CHECKOUT, 3'd4, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    // Empty pool.
    cfg_row(5'd0);
    req_row(REQ_CHECKOUT, 3'd6, 4'd0,  1, ST_ALL_BUSY,     4'd0, 5'd2, 32'd6);
    req_row(REQ_CHECKIN,  3'd4, 4'd0,  1, ST_INVALID,      4'd0, 5'd2, 32'd6);
    req_row(REQ_RELEASE,  3'd0, 4'd0,  1, ST_INVALID,      4'd0, 5'd2, 32'd6);
    // Oversized setting saturates at the full pool.
    cfg_row(5'd31);
    req_row(REQ_CHECKOUT, 3'd2, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_RELEASE,  3'd0, 4'd1,  0, ST_OK, 4'd0, 5'd0, 32'd0);
    req_row(REQ_CHECKIN,  3'd4, 4'd0,  0, ST_OK, 4'd0, 5'd0, 32'd0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) write_pool(dir_rows[k].pool);
      else send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp);
    end

    for (int p = 0; p < 10; p++) begin
      write_pool(phase_pool[p]);
      gap_cap   = (p % 3 == 1) ? 0 : 18;
      stall_cap = (p % 4 == 2) ? 0 : 18;
      repeat (ITEMS_PER_PHASE) send_request(draw_request(), 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (bad_replies == 0) begin
      $display("buffer_pool_owner_allocator_unit: match");
    end else begin
      $display("buffer_pool_owner_allocator_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: buffer_pool_owner_allocator_unit.f
rtl/core/bpoa_pkg.sv
rtl/core/bpoa_ram.sv
rtl/core/buffer_pool_owner_allocator_unit.sv
sim/tb_buffer_pool_owner_allocator_unit.sv
